FILE: design/int_to_decimal_ascii_formatter_assert.svh
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_formatter_assert.svh
// assertion macros for the decimal ascii formatter
// ----------------------------------------------------------------------------
`ifndef INT_TO_DECIMAL_ASCII_FORMATTER_ASSERT_SVH
`define INT_TO_DECIMAL_ASCII_FORMATTER_ASSERT_SVH

`ifndef ASSERT_OFF

// condition holds at every clock edge out of reset
`define FMT_ASSERT_ALWAYS(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent on the next clock edge
`define FMT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FMT_ASSERT_ALWAYS(name, clk, rst_n, cond, msg)
`define FMT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: design/itoa_fmt_pkg.sv
// ----------------------------------------------------------------------------
// itoa_fmt_pkg
// types and constants shared by the decimal ascii formatter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package itoa_fmt_pkg;

    // buffer and conversion sizes
    localparam int MaxLengthInt = 16;
    localparam logic [4:0] MaxLength = 5'(MaxLengthInt);
    localparam int MagWidth = 32;
    localparam int NumDigits = 10;
    localparam int BcdWidth = 4 * NumDigits;

    // command codes
    localparam logic CmdLeft = 1'b0;
    localparam logic CmdRight = 1'b1;

    // character codes
    localparam logic [7:0] CharZero = 8'h30;
    localparam logic [7:0] CharMinus = 8'h2d;
    localparam logic [7:0] CharNul = 8'h00;

    // command transaction
    typedef struct packed {
        logic               command;
        logic signed [31:0] value;
        logic [4:0]         buffer_length;
        logic [7:0]         fill_char;
    } cmd_t;

    // result transaction
    typedef struct packed {
        logic [7:0] character;
        logic [3:0] position;
        logic       char_valid;
        logic       last;
        logic [4:0] count;
    } res_t;

endpackage

FILE: design/int_to_decimal_ascii_formatter.sv
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_formatter
// converts a signed 32-bit value to decimal ascii, one character per result
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  cmd      | in        | cmd_valid / cmd_stall | cmd_data (itoa_fmt_pkg::cmd_t)
//  res      | out       | res_valid / res_stall | res_data (itoa_fmt_pkg::res_t)
//
//  a transaction passes idle, conversion, prep and emit, giving n results (1 to 16):
//  the conversion uses the shared shift-add-3 unit, one magnitude bit per cycle.
//  cmd_stall stays high from acceptance until the last result is loaded.
//  res_stall holds the result register; emission waits while it is full and stalled.
//  reset clears the sequencer and the result valid flag only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "int_to_decimal_ascii_formatter_assert.svh"

module int_to_decimal_ascii_formatter (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  itoa_fmt_pkg::cmd_t   cmd_data,
    output logic                 res_valid,
    input  logic                 res_stall,
    output itoa_fmt_pkg::res_t   res_data
);
    import itoa_fmt_pkg::*;

    localparam logic [1:0] StIdle = 2'd0;
    localparam logic [1:0] StConv = 2'd1;
    localparam logic [1:0] StPrep = 2'd2;
    localparam logic [1:0] StEmit = 2'd3;

    localparam logic [4:0] LastIter = 5'(MagWidth - 1);

    logic [1:0]          state_reg, state_next;
    logic [4:0]          iter_reg, iter_next;
    logic [MagWidth-1:0] mag_reg, mag_next;
    logic [BcdWidth-1:0] bcd_reg, bcd_next;
    logic                neg_reg, neg_next;
    logic                right_reg, right_next;
    logic [4:0]          len_reg, len_next;
    logic [7:0]          fill_reg, fill_next;
    logic [3:0]          k_reg, k_next;
    logic [4:0]          room_reg, room_next;
    logic [4:0]          total_reg, total_next;
    logic [4:0]          pos_reg, pos_next;
    logic                res_valid_reg, res_valid_next;
    res_t                res_reg, res_next;

    logic [BcdWidth-1:0] bcd_adj;
    logic [3:0]          nd;
    logic [3:0]          k_calc;
    logic [4:0]          room_calc;
    logic [4:0]          sign_ext;
    logic [4:0]          q;
    logic [4:0]          gap;
    logic [4:0]          dig_idx;
    logic [3:0]          dig_sel;
    logic [7:0]          emit_char;
    logic                emit_last;
    logic                load_res;
    logic [4:0]          len_sat;

    // digit of the bcd register at a runtime index
    function automatic logic [3:0] digit_at(input logic [BcdWidth-1:0] bcd,
                                           input logic [3:0] idx);
        logic [3:0] d;
        d = 4'd0;
        for (int i = 0; i < NumDigits; i++) begin
            if (idx == 4'(i))
            begin
                d = bcd[4*i +: 4];
            end
        end
        return d;
    endfunction

    // shared shift-add-3 unit: correct every digit, then shift in one bit
    always_comb
    begin
        for (int i = 0; i < NumDigits; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    // significant digit count and the digits that fit
    always_comb
    begin
        nd = 4'd1;
        for (int i = 1; i < NumDigits; i++) begin
            if (bcd_reg[4*i +: 4] != 4'd0)
            begin
                nd = 4'(i + 1);
            end
        end
        sign_ext = {4'd0, neg_reg};
        room_calc = len_reg - sign_ext;
        k_calc = ({1'b0, nd} < room_calc) ? nd : room_calc[3:0];
    end

    // character for the current position
    always_comb
    begin
        q = pos_reg - sign_ext;
        gap = room_reg - {1'b0, k_reg};
        dig_idx = 5'd0;
        emit_char = CharNul;
        if (neg_reg && (pos_reg == 5'd0))
        begin
            emit_char = CharMinus;
        end
        else if (right_reg == CmdRight)
        begin
            if (q < gap)
            begin
                emit_char = fill_reg;
            end
            else
            begin
                dig_idx = room_reg - 5'd1 - q;
                emit_char = CharZero + {4'd0, dig_sel};
            end
        end
        else
        begin
            if (q < {1'b0, k_reg})
            begin
                dig_idx = {1'b0, k_reg} - 5'd1 - q;
                emit_char = CharZero + {4'd0, dig_sel};
            end
        end
    end

    assign dig_sel = digit_at(bcd_reg, dig_idx[3:0]);
    assign emit_last = ((pos_reg + 5'd1) == total_reg);
    assign load_res = (state_reg == StEmit) && (!res_valid_reg || !res_stall);
    assign len_sat = (cmd_data.buffer_length > MaxLength) ? MaxLength
                                                          : cmd_data.buffer_length;

    // sequencer and datapath next state
    always_comb
    begin
        state_next = state_reg;
        iter_next = iter_reg;
        mag_next = mag_reg;
        bcd_next = bcd_reg;
        neg_next = neg_reg;
        right_next = right_reg;
        len_next = len_reg;
        fill_next = fill_reg;
        k_next = k_reg;
        room_next = room_reg;
        total_next = total_reg;
        pos_next = pos_reg;
        res_valid_next = res_valid_reg;
        res_next = res_reg;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            StIdle:
            begin
                if (cmd_valid)
                begin
                    neg_next = cmd_data.value[31];
                    mag_next = cmd_data.value[31] ? (32'd0 - unsigned'(cmd_data.value))
                                                  : unsigned'(cmd_data.value);
                    right_next = cmd_data.command;
                    len_next = len_sat;
                    fill_next = cmd_data.fill_char;
                    bcd_next = '0;
                    iter_next = 5'd0;
                    state_next = StConv;
                end
            end
            StConv:
            begin
                bcd_next = {bcd_adj[BcdWidth-2:0], mag_reg[MagWidth-1]};
                mag_next = {mag_reg[MagWidth-2:0], 1'b0};
                iter_next = iter_reg + 5'd1;
                if (iter_reg == LastIter)
                begin
                    state_next = StPrep;
                end
            end
            StPrep:
            begin
                pos_next = 5'd0;
                k_next = k_calc;
                room_next = room_calc;
                if (len_reg == 5'd0)
                begin
                    total_next = 5'd1;
                end
                else if (right_reg == CmdRight)
                begin
                    total_next = len_reg;
                end
                else if ((sign_ext + {1'b0, k_calc}) < len_reg)
                begin
                    total_next = sign_ext + {1'b0, k_calc} + 5'd1;
                end
                else
                begin
                    total_next = sign_ext + {1'b0, k_calc};
                end
                state_next = StEmit;
            end
            StEmit:
            begin
                if (load_res)
                begin
                    res_valid_next = 1'b1;
                    if (len_reg == 5'd0)
                    begin
                        res_next.character = CharNul;
                        res_next.position = 4'd0;
                        res_next.char_valid = 1'b0;
                        res_next.last = 1'b1;
                        res_next.count = 5'd0;
                    end
                    else
                    begin
                        res_next.character = emit_char;
                        res_next.position = pos_reg[3:0];
                        res_next.char_valid = 1'b1;
                        res_next.last = emit_last;
                        res_next.count = emit_last ? (sign_ext + {1'b0, k_reg}) : 5'd0;
                    end
                    pos_next = pos_reg + 5'd1;
                    if (emit_last)
                    begin
                        state_next = StIdle;
                    end
                end
            end
            default:
            begin
                state_next = StIdle;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= StIdle;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        iter_reg <= iter_next;
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
        right_reg <= right_next;
        len_reg <= len_next;
        fill_reg <= fill_next;
        k_reg <= k_next;
        room_reg <= room_next;
        total_reg <= total_next;
        pos_reg <= pos_next;
        res_reg <= res_next;
    end

    assign cmd_stall = (state_reg != StIdle);
    assign res_valid = res_valid_reg;
    assign res_data = res_reg;

    // checks
    `FMT_ASSERT_NEXT(a_conv_ends, clk, rst_n,
        (state_reg == StConv) && (iter_reg == LastIter), state_reg == StPrep,
        "conversion did not end after the last magnitude bit")

    `FMT_ASSERT_ALWAYS(a_pos_in_range, clk, rst_n,
        (state_reg != StEmit) || (pos_reg < total_reg),
        "emit position ran past the result count")

    `FMT_ASSERT_ALWAYS(a_digits_fit, clk, rst_n,
        (state_reg != StEmit) || (len_reg == 5'd0) ||
        ((k_reg <= 4'(NumDigits)) && ({1'b0, k_reg} <= room_reg)),
        "kept digit count exceeds buffer room")

endmodule
